// ===== hdl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table modules.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int SLOTS = 1024;
	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = SW + 1;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_QUERY   = 2'd2,
		OP_FIND    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_STALE = 2'd2,
		ST_NOKEY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_C0,
		S_C_FS,
		S_C_RD,
		S_C_WR,
		S_SCAN,
		S_D_RD,
		S_D_CHK,
		S_D_MOV,
		S_D_MWR,
		S_D_FIN,
		S_Q_RD,
		S_Q_CHK,
		S_RESP
	} state_t;

	// One decoded request word.
	typedef struct packed {
		op_t         op;
		logic [31:0] owner;
		logic [31:0] key;
		logic [9:0]  hidx;
		logic [31:0] hgen;
	} item_t;

	// Per-slot record held in the slot memory.
	typedef struct packed {
		logic [31:0]   gen;
		logic          alive;
		logic          mapped;
		logic [SW-1:0] dense;
		logic [31:0]   owner;
		logic [31:0]   key;
	} slot_word_t;

	// Result word, last field in the lowest bits.
	typedef struct packed {
		logic [9:0]  move_to;
		logic [9:0]  move_from;
		logic        alive;
		logic [31:0] key_out;
		logic [31:0] owner_out;
		logic [9:0]  dense_pos;
		logic [31:0] out_generation;
		logic [9:0]  out_index;
		status_t     status;
	} res_t;

	// Occupancy counters of the back end.
	typedef struct packed {
		logic [CW-1:0] free_count;
		logic [CW-1:0] slots_made;
		logic [CW-1:0] live_count;
	} cnt_t;

endpackage

// ===== hdl/ght_front.sv =====
// ----------------------------------------------------------------------------
// ght_front
// Accepts request words, decodes the mode and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module ght_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [111:0]         in_data,
	output logic                 q_valid,
	output ght_pkg::item_t       q_item,
	input  logic                 q_pop
);
	import ght_pkg::*;

	item_t      fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	item_t      dec;
	logic       push;
	logic       pop;

	always_comb begin
		case (in_data[1:0])
			2'd0:    dec.op = OP_CREATE;
			2'd1:    dec.op = OP_DESTROY;
			2'd2:    dec.op = OP_QUERY;
			default: dec.op = OP_FIND;
		endcase
		dec.owner = in_data[33:2];
		dec.key   = in_data[65:34];
		dec.hidx  = in_data[75:66];
		dec.hgen  = in_data[107:76];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= dec;
	end

endmodule

// ===== hdl/ght_back.sv =====
// ----------------------------------------------------------------------------
// ght_back
// Executes create, destroy, query and find against the slot, free-stack and
// dense memories; the key map is a mapped flag per slot found by a scan.
// ----------------------------------------------------------------------------
module ght_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ght_pkg::item_t       q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ght_pkg::res_t        out_res,
	output ght_pkg::cnt_t        cnt
);
	import ght_pkg::*;

	slot_word_t    slot_mem [SLOTS];
	logic [SW-1:0] fs_mem   [SLOTS];
	logic [SW-1:0] dts_mem  [SLOTS];

	state_t        st_q, st_nxt;
	item_t         it_q;
	logic [CW-1:0] fc_q, made_q, live_q;
	logic [SW-1:0] s_q, moved_q, scan_i_q, idx_s1;
	logic          new_q, pv_s1, ov_q;
	slot_word_t    hw_q, slot_rd_q;
	logic [SW-1:0] fs_rd_q, dts_rd_q;
	res_t          res_q, out_q;

	// memory port controls
	logic          slot_re, slot_we, fs_re, fs_we, dts_re, dts_we;
	logic [SW-1:0] slot_ra, slot_wa, fs_ra, fs_wa, dts_ra, dts_wa;
	logic [SW-1:0] dts_wd, fs_wd;
	slot_word_t    slot_wd;

	logic [CW-1:0] lm1;
	logic [CW-1:0] fcm1;
	logic [31:0]   skey;
	logic          h_ok, live_ok, match, scan_end, scan_done;

	assign lm1      = live_q - CW'(1);
	assign fcm1     = fc_q - CW'(1);
	assign h_ok     = ({{(CW-10){1'b0}}, it_q.hidx} < made_q);
	assign live_ok  = slot_rd_q.alive && (slot_rd_q.gen == it_q.hgen);
	assign skey     = (it_q.op == OP_DESTROY) ? hw_q.key : it_q.key;
	assign match    = pv_s1 && slot_rd_q.alive && slot_rd_q.mapped && (slot_rd_q.key == skey);
	assign scan_end = pv_s1 && (({1'b0, idx_s1} + CW'(1)) == made_q);
	assign scan_done = match || scan_end || (made_q == '0);

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						OP_CREATE:  st_nxt = S_C0;
						OP_DESTROY: st_nxt = S_D_RD;
						OP_QUERY:   st_nxt = S_Q_RD;
						default:    st_nxt = S_SCAN;
					endcase
				end
			end
			S_C0: begin
				if (fc_q != '0)                st_nxt = S_C_FS;
				else if (made_q < CW'(SLOTS))  st_nxt = S_SCAN;
				else                           st_nxt = S_RESP;
			end
			S_C_FS:  st_nxt = S_SCAN;
			S_SCAN: begin
				if (scan_done) st_nxt = (it_q.op == OP_CREATE) ? S_C_RD : S_RESP;
			end
			S_C_RD:  st_nxt = S_C_WR;
			S_C_WR:  st_nxt = S_RESP;
			S_D_RD:  st_nxt = h_ok ? S_D_CHK : S_RESP;
			S_D_CHK: st_nxt = live_ok ? S_D_MOV : S_RESP;
			S_D_MOV: st_nxt = (dts_rd_q != it_q.hidx) ? S_D_MWR : S_D_FIN;
			S_D_MWR: st_nxt = S_D_FIN;
			S_D_FIN: st_nxt = hw_q.mapped ? S_RESP : S_SCAN;
			S_Q_RD:  st_nxt = h_ok ? S_Q_CHK : S_RESP;
			S_Q_CHK: st_nxt = S_RESP;
			S_RESP:  if (!ov_q || out_ready) st_nxt = S_IDLE;
			default: st_nxt = S_IDLE;
		endcase
	end

	// memory port outputs
	always_comb begin
		slot_re = 1'b0; slot_ra = it_q.hidx;
		slot_we = 1'b0; slot_wa = it_q.hidx; slot_wd = hw_q;
		fs_re   = 1'b0; fs_ra   = lm1[SW-1:0];
		fs_we   = 1'b0; fs_wa   = fc_q[SW-1:0]; fs_wd = it_q.hidx;
		dts_re  = 1'b0; dts_ra  = lm1[SW-1:0];
		dts_we  = 1'b0; dts_wa  = live_q[SW-1:0]; dts_wd = s_q;
		q_pop   = (st_q == S_IDLE) && q_valid;
		case (st_q)
			S_C0: begin
				fs_re = (fc_q != '0);
				fs_ra = fcm1[SW-1:0];
			end
			S_SCAN: begin
				slot_re = 1'b1;
				slot_ra = scan_i_q;
				if (match && it_q.op != OP_FIND) begin
					slot_we        = 1'b1;
					slot_wa        = idx_s1;
					slot_wd        = slot_rd_q;
					slot_wd.mapped = 1'b0;
				end
			end
			S_C_RD: begin
				slot_re = 1'b1;
				slot_ra = s_q;
			end
			S_C_WR: begin
				slot_we       = 1'b1;
				slot_wa       = s_q;
				slot_wd.gen   = new_q ? 32'd1 : slot_rd_q.gen;
				slot_wd.alive = 1'b1;
				slot_wd.mapped = 1'b1;
				slot_wd.dense = live_q[SW-1:0];
				slot_wd.owner = it_q.owner;
				slot_wd.key   = it_q.key;
				dts_we        = 1'b1;
			end
			S_D_RD, S_Q_RD: slot_re = h_ok;
			S_D_CHK: dts_re = live_ok;
			S_D_MOV: begin
				dts_we  = 1'b1;
				dts_wa  = hw_q.dense;
				dts_wd  = dts_rd_q;
				slot_re = 1'b1;
				slot_ra = dts_rd_q;
			end
			S_D_MWR: begin
				slot_we       = 1'b1;
				slot_wa       = moved_q;
				slot_wd       = slot_rd_q;
				slot_wd.dense = hw_q.dense;
			end
			S_D_FIN: begin
				slot_we        = 1'b1;
				slot_wd.alive  = 1'b0;
				slot_wd.mapped = 1'b0;
				slot_wd.gen    = hw_q.gen + 32'd1;
				fs_we          = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_re) slot_rd_q <= slot_mem[slot_ra];
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		if (fs_re)   fs_rd_q <= fs_mem[fs_ra];
		if (fs_we)   fs_mem[fs_wa] <= fs_wd;
		if (dts_re)  dts_rd_q <= dts_mem[dts_ra];
		if (dts_we)  dts_mem[dts_wa] <= dts_wd;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			fc_q     <= '0;
			made_q   <= '0;
			live_q   <= '0;
			ov_q     <= 1'b0;
			pv_s1    <= 1'b0;
			scan_i_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == S_SCAN) begin
				pv_s1    <= ({1'b0, scan_i_q} < made_q) && !scan_done;
				scan_i_q <= scan_i_q + SW'(1);
			end else begin
				pv_s1    <= 1'b0;
				scan_i_q <= '0;
			end
			if (st_q == S_C0) begin
				if (fc_q != '0)               fc_q   <= fcm1;
				else if (made_q < CW'(SLOTS)) made_q <= made_q + CW'(1);
			end
			if (st_q == S_C_WR) live_q <= live_q + CW'(1);
			if (st_q == S_D_FIN) begin
				live_q <= lm1;
				fc_q   <= fc_q + CW'(1);
			end
			if (st_q == S_RESP && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready)                         ov_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				it_q    <= q_item;
				res_q   <= '0;
			end
			S_C0: begin
				new_q <= (fc_q == '0);
				s_q   <= made_q[SW-1:0];
				if (fc_q == '0 && made_q >= CW'(SLOTS)) res_q.status <= ST_FULL;
			end
			S_C_FS: s_q <= fs_rd_q;
			S_SCAN: begin
				idx_s1 <= scan_i_q;
				if (scan_done && it_q.op == OP_FIND) begin
					if (match) begin
						res_q.out_index      <= 10'(idx_s1);
						res_q.out_generation <= slot_rd_q.gen;
					end else begin
						res_q.status <= ST_NOKEY;
					end
				end
			end
			S_C_WR: begin
				res_q.out_index      <= 10'(s_q);
				res_q.out_generation <= new_q ? 32'd1 : slot_rd_q.gen;
				res_q.dense_pos      <= 10'(live_q[SW-1:0]);
			end
			S_D_RD, S_Q_RD: if (!h_ok) res_q.status <= ST_STALE;
			S_D_CHK: begin
				hw_q <= slot_rd_q;
				if (!live_ok) res_q.status <= ST_STALE;
			end
			S_D_MOV: moved_q <= dts_rd_q;
			S_D_FIN: begin
				res_q.move_from <= 10'(lm1[SW-1:0]);
				res_q.move_to   <= 10'(hw_q.dense);
			end
			S_Q_CHK: begin
				if (live_ok) begin
					res_q.dense_pos <= 10'(slot_rd_q.dense);
					res_q.owner_out <= slot_rd_q.owner;
					res_q.key_out   <= slot_rd_q.key;
					res_q.alive     <= 1'b1;
				end else begin
					res_q.status <= ST_STALE;
				end
			end
			S_RESP: if (!ov_q || out_ready) out_q <= res_q;
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_res   = out_q;
	assign cnt.free_count = fc_q;
	assign cnt.slots_made = made_q;
	assign cnt.live_count = live_q;

endmodule

// ===== hdl/generational_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot map with generational handles, dense storage and a key map.
// ----------------------------------------------------------------------------
// Query needs no key scan; destroy adds a key scan when the slot no longer
// owns its map entry. Create runs a key scan unless the table is full; find
// is a key scan alone.
// The scan reads one slot record per cycle from the slot memory.
// One request executes at a time; a two-word queue buffers new requests.
// Reset clears counters and control only; no memory clearing pass is needed.
module generational_handle_table_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	// mode[1:0], owner[33:2], key[65:34], handle_index[75:66],
	// handle_generation[107:76], zero pad
	input  logic [111:0]   s_axis_tdata,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	// status[1:0], out_index[11:2], out_generation[43:12], dense_pos[53:44],
	// owner_out[85:54], key_out[117:86], alive[118], move_from[128:119],
	// move_to[138:129], zero pad
	output logic [143:0]   m_axis_tdata
);
	import ght_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;
	res_t  res;
	cnt_t  cnt;

	ght_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ght_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.cnt       (cnt)
	);

	assign m_axis_tdata = {5'd0, res};

	// every slot made is live, on the free stack, or being handed out
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		((cnt.slots_made - cnt.free_count - cnt.live_count) <= CW'(1)))
		else $error("slot accounting broken");

	a_made_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt.slots_made <= CW'(SLOTS)))
		else $error("slots_made beyond table size");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.status == ST_FULL) |->
		(cnt.slots_made == CW'(SLOTS)))
		else $error("full reported with slots available");

endmodule

// ===== sim/generational_handle_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_top_test
// Drives create, destroy, query and find words into the handle table, keeps
// a behavioral copy of the slot map and checks every result word in order.
// ----------------------------------------------------------------------------
module generational_handle_table_top_test;
	import ght_pkg::*;

	class handle_scoreboard;
		logic [31:0] gen_q [SLOTS];
		bit          alive_q [SLOTS];
		int          dense_q [SLOTS];
		logic [31:0] owner_q [SLOTS];
		logic [31:0] key_q [SLOTS];
		int          free_stack [SLOTS];
		int          free_n;
		int          made;
		int          live;
		int          dense_slot [SLOTS];
		logic [31:0] map_key [SLOTS];
		int          map_slot [SLOTS];
		bit          map_ok [SLOTS];
		res_t        pending [$];
		int          errors;
		int          checked;

		function new();
			made = 0;
			live = 0;
			free_n = 0;
			errors = 0;
			checked = 0;
			foreach (alive_q[i]) alive_q[i] = 0;
			foreach (map_ok[i]) map_ok[i] = 0;
		endfunction

		function int map_lookup(logic [31:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (map_ok[i] && map_key[i] == k) return i;
			return SLOTS;
		endfunction

		function bit is_live(int h, logic [31:0] g);
			return h < made && alive_q[h] && gen_q[h] == g;
		endfunction

		// Advance the table by one accepted word and queue its expected result.
		function void note_request(item_t it);
			res_t r;
			int s, d, last, moved, e;
			r = '0;
			r.status = ST_OK;
			case (it.op)
				OP_CREATE: begin
					if (free_n > 0) begin
						free_n--;
						s = free_stack[free_n];
					end else if (made < SLOTS) begin
						s = made;
						made++;
						gen_q[s] = 1;
					end else begin
						r.status = ST_FULL;
						s = -1;
					end
					if (s >= 0) begin
						d = live;
						live++;
						dense_slot[d] = s;
						alive_q[s] = 1;
						dense_q[s] = d;
						owner_q[s] = it.owner;
						key_q[s] = it.key;
						e = map_lookup(it.key);
						if (e == SLOTS)
							for (e = 0; e < SLOTS && map_ok[e]; e++) ;
						if (e < SLOTS) begin
							map_ok[e] = 1;
							map_key[e] = it.key;
							map_slot[e] = s;
						end
						r.out_index = 10'(s);
						r.out_generation = gen_q[s];
						r.dense_pos = 10'(d);
					end
				end
				OP_DESTROY: begin
					if (!is_live(it.hidx, it.hgen)) begin
						r.status = ST_STALE;
					end else begin
						s = it.hidx;
						d = dense_q[s];
						last = live - 1;
						moved = dense_slot[last];
						dense_slot[d] = moved;
						dense_q[moved] = d;
						live--;
						e = map_lookup(key_q[s]);
						if (e < SLOTS) map_ok[e] = 0;
						alive_q[s] = 0;
						free_stack[free_n] = s;
						free_n++;
						gen_q[s] = gen_q[s] + 1;
						r.move_from = 10'(last);
						r.move_to = 10'(d);
					end
				end
				OP_QUERY: begin
					if (!is_live(it.hidx, it.hgen)) begin
						r.status = ST_STALE;
					end else begin
						r.dense_pos = 10'(dense_q[it.hidx]);
						r.owner_out = owner_q[it.hidx];
						r.key_out = key_q[it.hidx];
						r.alive = 1;
					end
				end
				default: begin
					e = map_lookup(it.key);
					if (e == SLOTS) begin
						r.status = ST_NOKEY;
					end else begin
						r.out_index = 10'(map_slot[e]);
						r.out_generation = gen_q[map_slot[e]];
					end
				end
			endcase
			pending.insert(pending.size(), r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 40)
				$display("mismatch %0d %s: got %0h expected %0h", checked, what, got, want);
		endtask

		task check_result(res_t got);
			res_t w;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected word", got.status, 0);
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status) report("status", got.status, w.status);
			if (got.out_index !== w.out_index) report("out_index", got.out_index, w.out_index);
			if (got.out_generation !== w.out_generation)
				report("out_generation", got.out_generation, w.out_generation);
			if (got.dense_pos !== w.dense_pos) report("dense_pos", got.dense_pos, w.dense_pos);
			if (got.owner_out !== w.owner_out) report("owner_out", got.owner_out, w.owner_out);
			if (got.key_out !== w.key_out) report("key_out", got.key_out, w.key_out);
			if (got.alive !== w.alive) report("alive", got.alive, w.alive);
			if (got.move_from !== w.move_from) report("move_from", got.move_from, w.move_from);
			if (got.move_to !== w.move_to) report("move_to", got.move_to, w.move_to);
		endtask
	endclass

	localparam int LIMIT = 6000000;

	logic           clk;
	logic           arst_n;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	logic [111:0]   s_axis_tdata;
	logic           m_axis_tvalid;
	logic           m_axis_tready;
	logic [143:0]   m_axis_tdata;

	handle_scoreboard sb;
	int  cycles;
	bit  calm;          // no random idling while set
	bit  hold_off;      // receiver stalls while set
	int  n_create, n_destroy, n_query, n_find;
	logic [31:0] key_pool [8];

	generational_handle_table_top u_top (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: sample at the rising edge, change ready at the falling one.
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(res_t'(m_axis_tdata[138:0]));

	always @(negedge clk)
		m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 35);

	task automatic send_word(item_t it);
		while (!calm && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tdata <= {4'd0, it.hgen, it.hidx, it.key, it.owner, it.op};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(it);
		case (it.op)
			OP_CREATE: n_create++;
			OP_DESTROY: n_destroy++;
			OP_QUERY: n_query++;
			default: n_find++;
		endcase
		@(negedge clk);
	endtask

	// Drop valid, then wait on the falling clock edge.
	task automatic idle_input();
		s_axis_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		idle_input();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Pick a handle: mostly a made slot at its current generation, sometimes stale or never made.
	task automatic pick_handle(output logic [9:0] h, output logic [31:0] g);
		int k;
		k = $urandom_range(99);
		if (sb.made == 0 || k < 10) begin
			h = 10'($urandom);
			g = $urandom;
		end else begin
			h = 10'($urandom_range(sb.made - 1));
			g = sb.gen_q[h];
			if (k < 25) g = g - 1;
		end
	endtask

	task automatic random_word(int create_pct);
		item_t it;
		int k;
		it.owner = $urandom;
		it.key = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(7)];
		it.hidx = 10'($urandom);
		it.hgen = $urandom;
		k = $urandom_range(99);
		if (k < create_pct) it.op = OP_CREATE;
		else if (k < create_pct + (100 - create_pct) / 3) it.op = OP_DESTROY;
		else if (k < create_pct + 2 * (100 - create_pct) / 3) it.op = OP_QUERY;
		else it.op = OP_FIND;
		if (it.op == OP_DESTROY || it.op == OP_QUERY) pick_handle(it.hidx, it.hgen);
		send_word(it);
	endtask

	task automatic word(op_t op, logic [31:0] owner, logic [31:0] key,
			logic [9:0] h, logic [31:0] g);
		item_t it;
		it.op = op; it.owner = owner; it.key = key; it.hidx = h; it.hgen = g;
		send_word(it);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		calm = 0;
		hold_off = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		key_pool[0] = 0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, bad handles, shared key, last-entry destroy.
		word(OP_FIND, 0, 0, 0, 0);
		word(OP_QUERY, 0, 0, 0, 1);
		word(OP_DESTROY, 0, 0, 10'h3FF, 32'hFFFF_FFFF);
		word(OP_CREATE, 0, 0, 0, 0);
		word(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
		word(OP_CREATE, 32'h1234_5678, 0, 0, 0);
		word(OP_FIND, 0, 0, 0, 0);
		word(OP_QUERY, 0, 0, 1, 1);
		word(OP_QUERY, 0, 0, 1, 2);
		word(OP_DESTROY, 0, 0, 2, 1);
		word(OP_FIND, 0, 0, 0, 0);
		word(OP_DESTROY, 0, 0, 0, 1);
		word(OP_DESTROY, 0, 0, 0, 1);
		word(OP_QUERY, 0, 0, 0, 1);
		word(OP_CREATE, 5, 32'hFFFF_FFFF, 0, 0);
		word(OP_FIND, 0, 32'hFFFF_FFFF, 0, 0);
		word(OP_DESTROY, 0, 0, 1, 1);
		word(OP_FIND, 0, 32'hFFFF_FFFF, 0, 0);
		drain();

		// Long receiver stall while words keep coming.
		fork
			begin
				hold_off = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			begin
				repeat (40) random_word(40);
				idle_input();
			end
		join
		drain();

		// Fill to capacity with no idling, then go on to reach the table-full answer.
		calm = 1;
		while (sb.made < SLOTS || sb.free_n != 0) random_word(92);
		calm = 0;
		repeat (20) random_word(60);
		drain();
		// Then few creates, so destroys shrink the table again.
		repeat (100) random_word(5);
		drain();
		repeat (20) @(negedge clk);

		$display("covered %0d creates, %0d destroys, %0d queries, %0d finds",
			n_create, n_destroy, n_query, n_find);
		$display("checked %0d result words, table reached %0d made slots",
			sb.checked, sb.made);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
